FILE: rtl/lzbtd_pkg.sv
// shared types and constants for the lz bitstream token decoder
package lzbtd_pkg;

    localparam int TableEntries = 52;
    localparam int TabAddrW     = 6;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_MATCH   = 2'd1,
        KIND_END     = 2'd2,
        KIND_ERROR   = 2'd3
    } token_kind_t;

    typedef enum logic [3:0] {
        PH_FIRST     = 4'd0,
        PH_TABLE     = 4'd1,
        PH_FLAG      = 4'd2,
        PH_GAMMA     = 4'd3,
        PH_LENBITS   = 4'd4,
        PH_CLASSBITS = 4'd5,
        PH_OFFBITS   = 4'd6,
        PH_RUNLEN    = 4'd7,
        PH_RUNBYTES  = 4'd8,
        PH_LITBYTE   = 4'd9,
        PH_HALT      = 4'd10
    } phase_t;

    // controller to datapath
    typedef struct packed {
        logic load_byte;
        logic step;
        logic emit_ack;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
        logic res_valid;
        logic emit_next;
    } dp_status_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  lit;
        logic [15:0] len;
        logic [15:0] off;
    } result_t;

endpackage

FILE: rtl/lz_bitstream_token_decoder_top.sv
// lz bitstream token decoder top level
// sequence: a word is taken in idle, then the datapath steps once for each bit consumed,
// each field completed and each table lookup, returns to idle, and hands each result out
// a refill word brings 8 bits into the bit buffer; a literal word is itself the result byte
// throughput: one word at a time; a pending result stalls steps only when a second is due
// aresetn synchronous active low: empty bit buffer, first-byte phase; tables are not cleared
module lz_bitstream_token_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_token_kind,
    output logic [7:0]  m_literal_value,
    output logic [15:0] m_match_length,
    output logic [15:0] m_match_offset,
    output logic        m_last
);
    lzbtd_pkg::dp_cmd_t    cmd;
    lzbtd_pkg::dp_status_t status;
    lzbtd_pkg::result_t    res;

    lzbtd_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_last,
        .status, .cmd
    );

    lzbtd_datapath u_dp (
        .aclk, .aresetn, .cmd,
        .in_byte  (s_stream_byte),
        .in_start (s_frame_start),
        .status, .res
    );

    assign m_token_kind    = res.kind;
    assign m_literal_value = res.lit;
    assign m_match_length  = res.len;
    assign m_match_offset  = res.off;
endmodule

FILE: rtl/lzbtd_datapath.sv
// parse state, bit buffer, tables and one-step token logic
module lzbtd_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lzbtd_pkg::dp_cmd_t   cmd,
    input  logic [7:0]           in_byte,
    input  logic                 in_start,
    output lzbtd_pkg::dp_status_t status,
    output lzbtd_pkg::result_t   res
);
    logic [8:0]  buf_reg, buf_next;
    logic [15:0] base_mem [lzbtd_pkg::TableEntries];
    logic [3:0]  width_mem [lzbtd_pkg::TableEntries];
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] bacc_reg, bacc_next;
    lzbtd_pkg::phase_t ph_reg, ph_next;
    logic [4:0]  gi_reg, gi_next;
    logic [15:0] fa_reg, fa_next;
    logic [4:0]  rem_reg, rem_next;
    logic [15:0] hl_reg, hl_next;
    logic [5:0]  oc_reg, oc_next;
    logic [15:0] run_reg, run_next;
    logic        rv_reg, rv_next;
    logic        lk_reg, lk_next;
    lzbtd_pkg::result_t res_reg, res_next;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [15:0] wr_base;
    logic [3:0]  wr_width;
    logic        is_field, active, need_look, emit_now;
    logic [5:0]  sum7, c_idx, wa, ba;
    logic [15:0] tbase_g, tbase_c, hl_calc, base_rd_reg;
    logic [3:0]  twid_g, twid_c, wid_rd_reg;
    lzbtd_pkg::phase_t ph_eff;

    // table reads are registered; addresses follow the current phase
    assign wa       = (ph_reg == lzbtd_pkg::PH_GAMMA) ? {2'b00, gi_reg[3:0]} : c_idx;
    assign ba       = (ph_reg == lzbtd_pkg::PH_OFFBITS) ? oc_reg : {2'b00, gi_reg[3:0]};
    assign tbase_g  = base_rd_reg;
    assign twid_g   = wid_rd_reg;
    assign sum7     = oc_reg + fa_reg[5:0];
    assign c_idx    = (sum7 >= 6'(lzbtd_pkg::TableEntries)) ?
                      sum7 - 6'(lzbtd_pkg::TableEntries) : sum7;
    assign twid_c   = wid_rd_reg;
    assign tbase_c  = base_rd_reg;
    assign hl_calc  = tbase_g + fa_reg;

    assign ph_eff = (in_start && cmd.load_byte) ? lzbtd_pkg::PH_FIRST : ph_reg;
    assign is_field = (ph_reg == lzbtd_pkg::PH_TABLE) || (ph_reg == lzbtd_pkg::PH_LENBITS) ||
                      (ph_reg == lzbtd_pkg::PH_CLASSBITS) || (ph_reg == lzbtd_pkg::PH_OFFBITS) ||
                      (ph_reg == lzbtd_pkg::PH_RUNLEN);
    assign active = (is_field && rem_reg == 5'd0) ||
                    ((is_field || ph_reg == lzbtd_pkg::PH_FLAG ||
                      ph_reg == lzbtd_pkg::PH_GAMMA) && buf_reg > 9'd1);
    assign need_look = (rem_reg == 5'd0 && ((ph_reg == lzbtd_pkg::PH_LENBITS) ||
                        (ph_reg == lzbtd_pkg::PH_CLASSBITS) ||
                        (ph_reg == lzbtd_pkg::PH_OFFBITS))) ||
                       (ph_reg == lzbtd_pkg::PH_GAMMA && buf_reg > 9'd1 && buf_reg[0] &&
                        gi_reg < 5'd16);
    assign emit_now = (ph_reg == lzbtd_pkg::PH_OFFBITS && rem_reg == 5'd0) ||
                      (ph_reg == lzbtd_pkg::PH_GAMMA && buf_reg > 9'd1 &&
                       (buf_reg[0] ? (gi_reg == 5'd16) : (gi_reg == 5'd17)));

    assign status.busy      = active;
    assign status.res_valid = rv_reg;
    assign status.emit_next = emit_now;
    assign res              = res_reg;

    always_comb begin
        buf_next = buf_reg; cnt_next = cnt_reg; bacc_next = bacc_reg;
        ph_next = ph_reg; gi_next = gi_reg; fa_next = fa_reg; rem_next = rem_reg;
        hl_next = hl_reg; oc_next = oc_reg; run_next = run_reg;
        rv_next = rv_reg; res_next = res_reg; lk_next = lk_reg;
        wr_en = 1'b0; wr_addr = cnt_reg; wr_base = bacc_reg; wr_width = fa_reg[3:0];
        if (cmd.emit_ack) begin
            rv_next = 1'b0;
        end
        if (cmd.load_byte) begin
            lk_next = 1'b0;
            if (in_start) begin
                cnt_next = '0; bacc_next = 16'd1; gi_next = '0; hl_next = '0;
                oc_next = '0; run_next = '0;
            end
            res_next = '{kind: lzbtd_pkg::KIND_LITERAL, lit: in_byte, len: '0, off: '0};
            case (ph_eff)
                lzbtd_pkg::PH_FIRST: begin
                    buf_next = (in_byte != 8'd0) ? {1'b0, in_byte} : 9'd1;
                    cnt_next = '0; bacc_next = 16'd1;
                    ph_next = lzbtd_pkg::PH_TABLE; fa_next = '0; rem_next = 5'd4;
                end
                lzbtd_pkg::PH_LITBYTE: begin
                    rv_next = 1'b1; ph_next = lzbtd_pkg::PH_FLAG;
                end
                lzbtd_pkg::PH_RUNBYTES: begin
                    rv_next = 1'b1; run_next = run_reg - 16'd1;
                    if (run_reg == 16'd1) begin
                        ph_next = lzbtd_pkg::PH_FLAG;
                    end
                end
                lzbtd_pkg::PH_HALT: begin
                end
                default: begin
                    buf_next = {1'b1, in_byte};
                end
            endcase
        end else if (cmd.step && need_look && !lk_reg) begin
            // table lookup cycle
            lk_next = 1'b1;
        end else if (cmd.step) begin
            lk_next = 1'b0;
            if (is_field && rem_reg == 5'd0) begin
                fa_next = '0;
                case (ph_reg)
                    lzbtd_pkg::PH_TABLE: begin
                        wr_en = 1'b1;
                        wr_base = (cnt_reg[3:0] == 4'd0) ? 16'd1 : bacc_reg;
                        bacc_next = wr_base + (16'd1 << fa_reg[3:0]);
                        cnt_next = cnt_reg + 6'd1;
                        if (cnt_reg == 6'(lzbtd_pkg::TableEntries - 1)) begin
                            ph_next = lzbtd_pkg::PH_FLAG; rem_next = '0;
                        end else begin
                            rem_next = 5'd4;
                        end
                    end
                    lzbtd_pkg::PH_LENBITS: begin
                        hl_next = hl_calc; ph_next = lzbtd_pkg::PH_CLASSBITS;
                        if (hl_calc == 16'd1) begin
                            oc_next = 6'd48; rem_next = 5'd2;
                        end else if (hl_calc == 16'd2) begin
                            oc_next = 6'd32; rem_next = 5'd4;
                        end else begin
                            oc_next = 6'd16; rem_next = 5'd4;
                        end
                    end
                    lzbtd_pkg::PH_CLASSBITS: begin
                        oc_next = c_idx; ph_next = lzbtd_pkg::PH_OFFBITS;
                        rem_next = {1'b0, twid_c};
                    end
                    lzbtd_pkg::PH_OFFBITS: begin
                        rv_next = 1'b1;
                        res_next = '{kind: lzbtd_pkg::KIND_MATCH, lit: '0, len: hl_reg,
                                     off: tbase_c + fa_reg};
                        ph_next = lzbtd_pkg::PH_FLAG; rem_next = '0;
                    end
                    default: begin
                        run_next = fa_reg; rem_next = '0;
                        ph_next = (fa_reg != 16'd0) ? lzbtd_pkg::PH_RUNBYTES
                                                    : lzbtd_pkg::PH_FLAG;
                    end
                endcase
            end else if (buf_reg > 9'd1) begin
                buf_next = buf_reg >> 1;
                case (ph_reg)
                    lzbtd_pkg::PH_FLAG: begin
                        if (buf_reg[0]) begin
                            ph_next = lzbtd_pkg::PH_LITBYTE;
                        end else begin
                            ph_next = lzbtd_pkg::PH_GAMMA; gi_next = '0;
                        end
                    end
                    lzbtd_pkg::PH_GAMMA: begin
                        fa_next = '0;
                        if (buf_reg[0]) begin
                            if (gi_reg == 5'd16) begin
                                rv_next = 1'b1; ph_next = lzbtd_pkg::PH_HALT;
                                res_next = '{kind: lzbtd_pkg::KIND_END, lit: '0, len: '0,
                                             off: '0};
                            end else if (gi_reg == 5'd17) begin
                                ph_next = lzbtd_pkg::PH_RUNLEN; rem_next = 5'd16;
                            end else begin
                                ph_next = lzbtd_pkg::PH_LENBITS;
                                rem_next = {1'b0, twid_g};
                            end
                        end else begin
                            gi_next = gi_reg + 5'd1;
                            if (gi_reg == 5'd17) begin
                                rv_next = 1'b1; ph_next = lzbtd_pkg::PH_HALT;
                                res_next = '{kind: lzbtd_pkg::KIND_ERROR, lit: '0, len: '0,
                                             off: '0};
                            end
                        end
                    end
                    default: begin
                        fa_next = {fa_reg[14:0], buf_reg[0]};
                        rem_next = rem_reg - 5'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            base_mem[wr_addr]  <= wr_base;
            width_mem[wr_addr] <= wr_width;
        end
        base_rd_reg <= base_mem[ba];
        wid_rd_reg  <= width_mem[wa];
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        fa_reg  <= fa_next;
        hl_reg  <= hl_next;
        run_reg <= run_next;
        if (!aresetn) begin
            buf_reg <= 9'd1; cnt_reg <= '0; bacc_reg <= 16'd1; ph_reg <= lzbtd_pkg::PH_FIRST;
            gi_reg <= '0; rem_reg <= '0; oc_reg <= '0; rv_reg <= 1'b0; lk_reg <= 1'b0;
        end else begin
            buf_reg <= buf_next; cnt_reg <= cnt_next; bacc_reg <= bacc_next;
            ph_reg <= ph_next; gi_reg <= gi_next; rem_reg <= rem_next;
            oc_reg <= oc_next; rv_reg <= rv_next; lk_reg <= lk_next;
        end
    end
endmodule

FILE: rtl/lzbtd_ctrl.sv
// handshake controller: accepts words, steps the datapath, drives results
module lzbtd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_last,
    input  lzbtd_pkg::dp_status_t status,
    output lzbtd_pkg::dp_cmd_t    cmd
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_fire;
    logic   out_block;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_last    = !status.busy;
    assign out_fire  = m_valid && m_ready;
    // a second result is due while the first still waits
    assign out_block = status.res_valid && status.emit_next;

    always_comb begin
        cmd.load_byte = s_valid && s_ready;
        cmd.emit_ack  = out_fire;
        cmd.step      = (state_reg == ST_RUN) && status.busy && !out_block;
        state_next    = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_block || (status.res_valid && !status.busy)) begin
                    state_next = ST_OUT;
                end else if (!status.busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = m_last ? ST_IDLE : ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

FILE: rtl/lzbtd_checker.sv
// port checker for the lz bitstream token decoder
module lzbtd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_token_kind,
    input logic [7:0] m_literal_value
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind))
        else $error("result dropped while stalled");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("second word taken at once");
    a_lit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != lzbtd_pkg::KIND_LITERAL |-> m_literal_value == 8'd0)
        else $error("literal field set on non-literal");
endmodule

bind lz_bitstream_token_decoder_top lzbtd_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_token_kind,
    .m_literal_value
);
